// ===== src/vmc_pkg.sv =====
// ----------------------------------------------------------------------------
// vmc_pkg: shared types and constants of the vending controller
// Command and status codes, controller states, datapath operations and the
// coin denomination tables that both the controller and datapath use.
// ----------------------------------------------------------------------------
package vmc_pkg;

  // Field widths fixed by the interface.
  localparam int FIELD_W    = 8;
  localparam int PRICE_W    = 10;
  localparam int CMD_W      = 2;
  localparam int INDEX_W    = 3;
  localparam int STATUS_W   = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_PRICES = 4;

  // Coin denominations.
  localparam int NUM_COINS = 6;
  localparam int COIN_W    = 3;
  localparam logic [COIN_W-1:0] COIN_LAST = COIN_W'(NUM_COINS - 1);

  // Largest inserted sum is 255 * (1 + 5 + 10 + 25 + 100 + 200), below 2**17.
  localparam int MONEY_W = 17;

  // Reciprocals for the constant dividers: floor(2**RECIP_SH / value).
  localparam int RECIP_SH = 17;
  localparam int RECIP_W  = 18;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD_PRODUCT = 2'd0,
    CMD_LOAD_COIN    = 2'd1,
    CMD_SELECT       = 2'd2,
    CMD_PAY          = 2'd3
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_SOLD_OUT  = 3'd1,
    ST_NO_SEL    = 3'd2,
    ST_LOW_FUNDS = 3'd3,
    ST_NO_CHANGE = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SUM,
    S_CHECK,
    S_DIV_A,
    S_DIV_B,
    S_FIN
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_SUM,
    OP_SUB,
    OP_DIV_A,
    OP_DIV_B,
    OP_FINISH
  } dp_op_t;

  // Controller to datapath.
  typedef struct packed {
    logic              latch;
    dp_op_t            op;
    logic [COIN_W-1:0] coin;
  } ctl_t;

  // Datapath to controller.
  typedef struct packed {
    logic early_fail;
    logic funds_low;
  } sts_t;

  function automatic logic [FIELD_W-1:0] coin_val(input logic [COIN_W-1:0] k);
    logic [FIELD_W-1:0] v;
    case (k)
      3'd0:    v = 8'd1;
      3'd1:    v = 8'd5;
      3'd2:    v = 8'd10;
      3'd3:    v = 8'd25;
      3'd4:    v = 8'd100;
      3'd5:    v = 8'd200;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  function automatic logic [RECIP_W-1:0] coin_recip(input logic [COIN_W-1:0] k);
    logic [RECIP_W-1:0] r;
    case (k)
      3'd0:    r = 18'd131072;
      3'd1:    r = 18'd26214;
      3'd2:    r = 18'd13107;
      3'd3:    r = 18'd5242;
      3'd4:    r = 18'd1310;
      3'd5:    r = 18'd655;
      default: r = 18'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== src/vmc_ctrl.sv =====
// ----------------------------------------------------------------------------
// vmc_ctrl: sequencer of the vending controller
// Accepts a request, steps the datapath through summing, checking and the
// greedy change walk, and holds the result valid until it is taken.
// ----------------------------------------------------------------------------
module vmc_ctrl (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  input  logic [vmc_pkg::CMD_W-1:0]     in_cmd,
  output logic                          in_stall,
  output logic                          out_valid,
  input  logic                          out_stall,
  output vmc_pkg::ctl_t                 ctl,
  input  vmc_pkg::sts_t                 sts
);

  vmc_pkg::state_t                  state_r, state_nxt;
  logic [vmc_pkg::COIN_W-1:0]       coin_r, coin_nxt;
  logic                             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vmc_pkg::S_IDLE;
      coin_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      coin_r      <= coin_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    coin_nxt      = coin_r;
    out_valid_nxt = out_valid_r && out_stall;
    ctl.latch     = 1'b0;
    ctl.op        = vmc_pkg::OP_NONE;
    ctl.coin      = coin_r;
    unique case (state_r)
      vmc_pkg::S_IDLE: begin
        if (in_valid) begin
          ctl.latch = 1'b1;
          coin_nxt  = '0;
          state_nxt = (in_cmd == vmc_pkg::CMD_PAY) ? vmc_pkg::S_SUM : vmc_pkg::S_FIN;
        end
      end
      vmc_pkg::S_SUM: begin
        ctl.op = vmc_pkg::OP_SUM;
        if (coin_r == vmc_pkg::COIN_LAST) begin
          state_nxt = vmc_pkg::S_CHECK;
        end else begin
          coin_nxt = coin_r + 1'b1;
        end
      end
      vmc_pkg::S_CHECK: begin
        ctl.op = vmc_pkg::OP_SUB;
        if (sts.early_fail || sts.funds_low) begin
          state_nxt = vmc_pkg::S_FIN;
        end else begin
          coin_nxt  = vmc_pkg::COIN_LAST;
          state_nxt = vmc_pkg::S_DIV_A;
        end
      end
      vmc_pkg::S_DIV_A: begin
        ctl.op    = vmc_pkg::OP_DIV_A;
        state_nxt = vmc_pkg::S_DIV_B;
      end
      vmc_pkg::S_DIV_B: begin
        ctl.op = vmc_pkg::OP_DIV_B;
        if (coin_r == '0) begin
          state_nxt = vmc_pkg::S_FIN;
        end else begin
          coin_nxt  = coin_r - 1'b1;
          state_nxt = vmc_pkg::S_DIV_A;
        end
      end
      vmc_pkg::S_FIN: begin
        if (!out_valid_r || !out_stall) begin
          ctl.op        = vmc_pkg::OP_FINISH;
          out_valid_nxt = 1'b1;
          state_nxt     = vmc_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = vmc_pkg::S_IDLE;
      end
    endcase
  end

  assign in_stall  = (state_r != vmc_pkg::S_IDLE);
  assign out_valid = out_valid_r;

endmodule

// ===== src/vmc_datapath.sv =====
// ----------------------------------------------------------------------------
// vmc_datapath: storage and arithmetic of the vending controller
// Holds prices, stock and coin counts and the selection, sums the inserted
// coins, divides the remainder by each denomination and forms the result.
// ----------------------------------------------------------------------------
module vmc_datapath #(
  parameter int NUM_PRODUCTS = 4,
  parameter int COUNT_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  vmc_pkg::ctl_t                     ctl,
  output vmc_pkg::sts_t                     sts,
  input  logic                              cfg_we,
  input  logic [vmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vmc_pkg::PRICE_W-1:0]       cfg_data,
  input  logic [vmc_pkg::CMD_W-1:0]         in_cmd,
  input  logic [vmc_pkg::INDEX_W-1:0]       in_index,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_load_value,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_penny,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_nickel,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_dime,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_quarter,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_dollar,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_twodollar,
  output logic [vmc_pkg::STATUS_W-1:0]      out_status,
  output logic [vmc_pkg::PRICE_W-1:0]       out_price,
  output logic                              out_dispensed,
  output logic [1:0]                        out_product,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_penny,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_nickel,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_dime,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_quarter,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_dollar,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_twodollar
);

  localparam int PIDX_W  = (NUM_PRODUCTS > 1) ? $clog2(NUM_PRODUCTS) : 1;
  localparam int SEL_W   = (PIDX_W > vmc_pkg::INDEX_W) ? PIDX_W : vmc_pkg::INDEX_W;
  localparam int MW      = vmc_pkg::MONEY_W;
  localparam int PROD_W  = MW + vmc_pkg::RECIP_W;
  localparam int SC_W    = COUNT_BITS + vmc_pkg::FIELD_W;
  localparam int QC_W    = MW + vmc_pkg::FIELD_W;
  localparam int WW      = (SC_W > MW) ? SC_W : MW;
  localparam int NC      = vmc_pkg::NUM_COINS;

  // Configuration and long-lived state.
  logic [vmc_pkg::PRICE_W-1:0]   price_r  [vmc_pkg::NUM_PRICES];
  logic [COUNT_BITS-1:0]         pstock_r [NUM_PRODUCTS];
  logic [COUNT_BITS-1:0]         cstock_r [NC];
  logic [PIDX_W-1:0]             sel_r;
  logic                          sel_valid_r;

  // Request held for the length of its processing.
  vmc_pkg::cmd_t                 cmd_r;
  logic [vmc_pkg::INDEX_W-1:0]   idx_r;
  logic [COUNT_BITS-1:0]         val_r;
  logic [vmc_pkg::FIELD_W-1:0]   paid_r [NC];

  // Working registers.
  logic [MW-1:0]                 money_r;
  logic [MW-1:0]                 rest_r;
  logic [PROD_W-1:0]             prod_r;
  logic [SC_W-1:0]               stockc_r;
  logic [COUNT_BITS-1:0]         give_r [NC];

  logic [vmc_pkg::FIELD_W-1:0]   cval;
  logic [SEL_W-1:0]              idx_ext, sel_ext;
  logic [PIDX_W-1:0]             idx_p;
  logic                          idx_ok;
  logic [vmc_pkg::PRICE_W-1:0]   price_idx, price_sel;
  logic [COUNT_BITS-1:0]         sel_stock;

  logic [MW-1:0]                 q_est, q_fix, rem0, rem_fix, rest_nxt;
  logic [QC_W-1:0]               qc;
  logic                          fix, take_q;
  logic [COUNT_BITS-1:0]         give_nxt;

  vmc_pkg::status_t              res_status;
  logic [vmc_pkg::PRICE_W-1:0]   res_price;
  logic                          res_dispensed;
  logic [1:0]                    res_product;
  logic                          wr_pstock, wr_cstock, do_sel, do_buy;

  assign cval    = vmc_pkg::coin_val(ctl.coin);
  assign idx_ext = SEL_W'(idx_r);
  assign idx_p   = idx_ext[PIDX_W-1:0];
  assign idx_ok  = (int'(idx_r) < NUM_PRODUCTS);
  assign sel_ext = SEL_W'(sel_r);

  // Products without a price register read as free.
  assign price_idx = (idx_ext < SEL_W'(vmc_pkg::NUM_PRICES)) ? price_r[idx_ext[1:0]] : '0;
  assign price_sel = (sel_ext < SEL_W'(vmc_pkg::NUM_PRICES)) ? price_r[sel_ext[1:0]] : '0;
  assign sel_stock = pstock_r[sel_r];

  assign sts.early_fail = !sel_valid_r || (sel_stock == '0);
  assign sts.funds_low  = (money_r < MW'(price_sel));

  // Second half of one greedy step: the quotient estimate is at most one
  // short, so a single compare and subtract corrects it.
  always_comb begin
    q_est    = MW'(prod_r >> vmc_pkg::RECIP_SH);
    qc       = QC_W'(q_est) * QC_W'(cval);
    rem0     = MW'(QC_W'(rest_r) - qc);
    fix      = (rem0 >= MW'(cval));
    q_fix    = q_est + MW'(fix);
    rem_fix  = fix ? (rem0 - MW'(cval)) : rem0;
    take_q   = (q_fix < MW'(cstock_r[ctl.coin]));
    give_nxt = take_q ? COUNT_BITS'(q_fix) : cstock_r[ctl.coin];
    rest_nxt = take_q ? rem_fix : MW'(WW'(rest_r) - WW'(stockc_r));
  end

  // Result of the held request.
  always_comb begin
    res_status    = vmc_pkg::ST_OK;
    res_price     = '0;
    res_dispensed = 1'b0;
    res_product   = '0;
    wr_pstock     = 1'b0;
    wr_cstock     = 1'b0;
    do_sel        = 1'b0;
    do_buy        = 1'b0;
    case (cmd_r)
      vmc_pkg::CMD_LOAD_PRODUCT: begin
        wr_pstock = idx_ok;
      end
      vmc_pkg::CMD_LOAD_COIN: begin
        wr_cstock = (int'(idx_r) < NC);
      end
      vmc_pkg::CMD_SELECT: begin
        res_product = idx_r[1:0];
        if (idx_ok && (pstock_r[idx_p] != '0)) begin
          do_sel    = 1'b1;
          res_price = price_idx;
        end else begin
          res_status = vmc_pkg::ST_SOLD_OUT;
        end
      end
      default: begin
        if (!sel_valid_r) begin
          res_status = vmc_pkg::ST_NO_SEL;
        end else begin
          res_price   = price_sel;
          res_product = sel_ext[1:0];
          if (sel_stock == '0) begin
            res_status = vmc_pkg::ST_SOLD_OUT;
          end else if (money_r < MW'(price_sel)) begin
            res_status = vmc_pkg::ST_LOW_FUNDS;
          end else if (rest_r != '0) begin
            res_status = vmc_pkg::ST_NO_CHANGE;
          end else begin
            do_buy        = 1'b1;
            res_dispensed = 1'b1;
          end
        end
      end
    endcase
  end

  // Long-lived state, cleared by reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < vmc_pkg::NUM_PRICES; i++) begin
        price_r[i] <= '0;
      end
      for (int i = 0; i < NUM_PRODUCTS; i++) begin
        pstock_r[i] <= '0;
      end
      for (int i = 0; i < NC; i++) begin
        cstock_r[i] <= '0;
      end
      sel_r       <= '0;
      sel_valid_r <= 1'b0;
    end else begin
      if (cfg_we && (int'(cfg_index) < vmc_pkg::NUM_PRICES)) begin
        price_r[cfg_index[1:0]] <= cfg_data;
      end
      if (ctl.op == vmc_pkg::OP_FINISH) begin
        if (wr_pstock) begin
          pstock_r[idx_p] <= val_r;
        end
        if (wr_cstock) begin
          cstock_r[idx_r] <= val_r;
        end
        if (do_sel) begin
          sel_r       <= idx_p;
          sel_valid_r <= 1'b1;
        end
        if (do_buy) begin
          pstock_r[sel_r] <= sel_stock - 1'b1;
          for (int i = 0; i < NC; i++) begin
            cstock_r[i] <= cstock_r[i] - give_r[i];
          end
        end
      end
    end
  end

  // Request capture and working registers.
  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      cmd_r     <= vmc_pkg::cmd_t'(in_cmd);
      idx_r     <= in_index;
      val_r     <= COUNT_BITS'(in_load_value);
      paid_r[0] <= in_paid_penny;
      paid_r[1] <= in_paid_nickel;
      paid_r[2] <= in_paid_dime;
      paid_r[3] <= in_paid_quarter;
      paid_r[4] <= in_paid_dollar;
      paid_r[5] <= in_paid_twodollar;
      money_r   <= '0;
    end
    case (ctl.op)
      vmc_pkg::OP_SUM: begin
        money_r <= money_r + MW'(16'(paid_r[ctl.coin]) * 16'(cval));
      end
      vmc_pkg::OP_SUB: begin
        rest_r <= money_r - MW'(price_sel);
      end
      vmc_pkg::OP_DIV_A: begin
        prod_r   <= PROD_W'(rest_r) * PROD_W'(vmc_pkg::coin_recip(ctl.coin));
        stockc_r <= SC_W'(cstock_r[ctl.coin]) * SC_W'(cval);
      end
      vmc_pkg::OP_DIV_B: begin
        give_r[ctl.coin] <= give_nxt;
        rest_r           <= rest_nxt;
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (ctl.op == vmc_pkg::OP_FINISH) begin
      out_status    <= res_status;
      out_price     <= res_price;
      out_dispensed <= res_dispensed;
      out_product   <= res_product;
      out_change_penny     <= do_buy ? vmc_pkg::FIELD_W'(give_r[0]) : '0;
      out_change_nickel    <= do_buy ? vmc_pkg::FIELD_W'(give_r[1]) : '0;
      out_change_dime      <= do_buy ? vmc_pkg::FIELD_W'(give_r[2]) : '0;
      out_change_quarter   <= do_buy ? vmc_pkg::FIELD_W'(give_r[3]) : '0;
      out_change_dollar    <= do_buy ? vmc_pkg::FIELD_W'(give_r[4]) : '0;
      out_change_twodollar <= do_buy ? vmc_pkg::FIELD_W'(give_r[5]) : '0;
    end
  end

endmodule

// ===== src/vending_controller_greedy_change_top.sv =====
// ----------------------------------------------------------------------------
// vending_controller_greedy_change_top: vending controller with greedy change
// Keeps product stock and coin counts, answers select requests with the
// price, and on pay returns change from the largest coin down.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake            Contents
//   in_       input      in_valid / in_stall  cmd, index, load value, paid coins
//   out_      output     out_valid/out_stall  status, price, product, change
//   cfg_      input      cfg_valid/cfg_ready  price register index and value
//
// A load or select request is accepted in the idle state and goes straight to
// the finish step, which writes the result into the output register. A pay
// request is accepted, sums the inserted coins (one denomination per cycle
// through one small multiplier), runs the funds check and then the greedy
// change walk, where per denomination a reciprocal multiply (S_DIV_A) is
// followed by a correcting compare and subtract (S_DIV_B), and finally
// writes the result in the finish step.
// A pay that fails the selection, stock or funds check skips the change walk.
// The block takes one request at a time; in_stall is high while it works.
// The result sits in an output register, so a new request is accepted while
// the previous result still waits; a stalled output only holds the block in
// its final step. Reset is synchronous and clears all counts, prices and the
// selection. Configuration writes are always taken (cfg_ready is tied high).
//
module vending_controller_greedy_change_top #(
  parameter int NUM_PRODUCTS = 4,
  parameter int COUNT_BITS   = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Request channel.
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [vmc_pkg::CMD_W-1:0]         in_cmd,
  input  logic [vmc_pkg::INDEX_W-1:0]       in_index,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_load_value,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_penny,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_nickel,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_dime,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_quarter,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_dollar,
  input  logic [vmc_pkg::FIELD_W-1:0]       in_paid_twodollar,
  // Result channel.
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [vmc_pkg::STATUS_W-1:0]      out_status,
  output logic [vmc_pkg::PRICE_W-1:0]       out_price,
  output logic                              out_dispensed,
  output logic [1:0]                        out_product,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_penny,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_nickel,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_dime,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_quarter,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_dollar,
  output logic [vmc_pkg::FIELD_W-1:0]       out_change_twodollar,
  // Configuration channel.
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [vmc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [vmc_pkg::PRICE_W-1:0]       cfg_data
);

  vmc_pkg::ctl_t ctl;
  vmc_pkg::sts_t sts;

  // Price registers are plain flops, so a write can land on any cycle.
  assign cfg_ready = 1'b1;

  // The controller sequences each request; it sees only the command code of
  // the incoming request and the two check results of the datapath.
  vmc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_cmd    (in_cmd),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .ctl       (ctl),
    .sts       (sts)
  );

  // The datapath holds all counts and prices and drives the result fields.
  vmc_datapath #(
    .NUM_PRODUCTS (NUM_PRODUCTS),
    .COUNT_BITS   (COUNT_BITS)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .ctl                  (ctl),
    .sts                  (sts),
    .cfg_we               (cfg_valid && cfg_ready),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_cmd               (in_cmd),
    .in_index             (in_index),
    .in_load_value        (in_load_value),
    .in_paid_penny        (in_paid_penny),
    .in_paid_nickel       (in_paid_nickel),
    .in_paid_dime         (in_paid_dime),
    .in_paid_quarter      (in_paid_quarter),
    .in_paid_dollar       (in_paid_dollar),
    .in_paid_twodollar    (in_paid_twodollar),
    .out_status           (out_status),
    .out_price            (out_price),
    .out_dispensed        (out_dispensed),
    .out_product          (out_product),
    .out_change_penny     (out_change_penny),
    .out_change_nickel    (out_change_nickel),
    .out_change_dime      (out_change_dime),
    .out_change_quarter   (out_change_quarter),
    .out_change_dollar    (out_change_dollar),
    .out_change_twodollar (out_change_twodollar)
  );

`ifndef SYNTHESIS
  // The block always goes busy right after it accepts a request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("request accepted but block did not go busy");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without a request in flight");

  // A released product always comes with an OK status.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_dispensed) |-> (out_status == vmc_pkg::ST_OK))
    else $error("product released with a failure status");

  // A failed request returns no coins.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != vmc_pkg::ST_OK)) |->
      (!out_dispensed && (out_change_penny == '0) && (out_change_nickel == '0) &&
       (out_change_dime == '0) && (out_change_quarter == '0) &&
       (out_change_dollar == '0) && (out_change_twodollar == '0)))
    else $error("change returned on a failed request");
`endif

endmodule
